@@ rtl/core/mfde_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Framebuffer draw engine package
// Shared constants, operation codes, sequencer states and the request format
// of the shared remainder adder.
// ----------------------------------------------------------------------------
package mfde_pkg;

   // default panel geometry: columns and 8-row pages
   localparam int DEF_SCREEN_WIDTH = 128;
   localparam int DEF_PAGE_COUNT   = 8;

   // coordinate width and width of the signed remainder / quotient / row
   localparam int COORD_W = 8;
   localparam int REM_W   = 10;

   // operation codes
   localparam logic [1:0] OP_POINT = 2'd0;
   localparam logic [1:0] OP_LINE  = 2'd1;
   localparam logic [1:0] OP_FILL  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // pen codes
   localparam logic [1:0] PEN_ERASE  = 2'd0;
   localparam logic [1:0] PEN_SET    = 2'd1;
   localparam logic [1:0] PEN_INVERT = 2'd2;

   localparam logic [7:0] BYTE_ONES  = 8'hff;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;

   // sequencer states
   typedef enum logic [9:0] {
      S_CLEAR     = 10'b00_0000_0001,
      S_IDLE      = 10'b00_0000_0010,
      S_NORM      = 10'b00_0000_0100,
      S_PLOT_RD   = 10'b00_0000_1000,
      S_PLOT_WR   = 10'b00_0001_0000,
      S_ADVANCE   = 10'b00_0010_0000,
      S_FILL      = 10'b00_0100_0000,
      S_READ      = 10'b00_1000_0000,
      S_READ_WAIT = 10'b01_0000_0000,
      S_DONE      = 10'b10_0000_0000
   } state_type;

   // operands of the shared adder, two's complement
   typedef struct packed {
      logic [REM_W-1:0] a;
      logic [REM_W-1:0] b;
      logic             sub;
   } alu_req_type;

endpackage
`default_nettype wire

@@ rtl/core/mfde_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Draw command channel
// Valid/ready channel carrying one drawing or read command word.
// ----------------------------------------------------------------------------
interface mfde_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] x_start;
   logic [7:0] y_start;
   logic [7:0] x_end;
   logic [7:0] y_end;
   logic [1:0] pen;
   logic [6:0] read_column;
   logic [2:0] read_page;

   modport source (
      output valid, op, x_start, y_start, x_end, y_end, pen, read_column, read_page,
      input  ready
   );
   modport sink (
      input  valid, op, x_start, y_start, x_end, y_end, pen, read_column, read_page,
      output ready
   );
endinterface
`default_nettype wire

@@ rtl/core/mfde_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Draw response channel
// Valid/ready channel carrying one response word per command.
// ----------------------------------------------------------------------------
interface mfde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (
      output valid, read_data,
      input  ready
   );
   modport sink (
      input  valid, read_data,
      output ready
   );
endinterface
`default_nettype wire

@@ rtl/core/mfde_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shared remainder adder
// Single add/subtract unit reused by the sequencer for remainder stepping
// and for the remainder-versus-span normalization compare.
// ----------------------------------------------------------------------------
module mfde_alu (
   input  mfde_pkg::alu_req_type               alu_req,
   output logic [mfde_pkg::REM_W-1:0]          alu_sum
);

   // add or subtract, wrap in two's complement
   always_comb begin
      if (alu_req.sub) begin
         alu_sum = alu_req.a - alu_req.b;
      end else begin
         alu_sum = alu_req.a + alu_req.b;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/mfde_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel store
// Byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mfde_store #(
   parameter int DEPTH = mfde_pkg::DEF_SCREEN_WIDTH * mfde_pkg::DEF_PAGE_COUNT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/mono_framebuffer_draw_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Monochrome framebuffer draw engine
// Page-organized pixel store with point, line, fill and byte read commands.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one command word at a time (ready only while idle);
//   rsp_chan returns exactly one word per command: the byte read for a read
//   command, zero otherwise. The response sits in an output register and the
//   next command is taken while it waits; a stalled receiver only holds the
//   command after that in its final step.
//   Reset starts a clearing pass over all SCREEN_WIDTH*PAGE_COUNT bytes (1024 at
//   the defaults) that zeroes the store; no command is taken meanwhile.
//   Steps of each command, from acceptance to response valid:
//     point: walked as a line of a single column; no store access off screen.
//     line:  each walked column (or row, for a vertical line) takes normalize,
//            read, write and advance steps, with no write for an off-screen
//            pixel, plus a normalize step per remainder correction and a
//            final step; each pixel is a read-modify-write of the store.
//     fill:  one byte per cycle over the whole store; straight to the final
//            step when the pen leaves the store unchanged.
//     read:  waits on the registered store read, or skips it out of range.
//   A sloped line steps the remainder with one shared adder in a sequencer.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine #(
   parameter int SCREEN_WIDTH = mfde_pkg::DEF_SCREEN_WIDTH,
   parameter int PAGE_COUNT   = mfde_pkg::DEF_PAGE_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   mfde_req_if.sink   req_chan,
   mfde_rsp_if.source rsp_chan
);

   localparam int DEPTH  = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROWS   = PAGE_COUNT * 8;
   localparam int REM_W  = mfde_pkg::REM_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   // sequencer and walk registers
   mfde_pkg::state_type state_ff, state_in;
   logic [1:0]          pen_ff, pen_in;
   logic                vert_ff, vert_in;
   logic [7:0]          cur_ff, cur_in;
   logic [7:0]          last_ff, last_in;
   logic [7:0]          fix_ff, fix_in;
   logic [REM_W-1:0]    dy_ff, dy_in;
   logic [7:0]          span_ff, span_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    quo_ff, quo_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          data_ff, data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;

   // command decode
   logic [7:0] x_a, y_a, x_b, y_b;
   logic       swap, vert_cmd;
   logic [7:0] x_lo, x_hi, y_at_lo, y_at_hi, y_min, y_max;
   logic       read_in_range;
   logic [ADDR_W-1:0] read_addr;

   // pixel position
   logic [7:0]        pix_col;
   logic [REM_W-1:0]  pix_row;
   logic              pix_on;
   logic [ADDR_W-1:0] pix_addr;
   logic [7:0]        pix_mask;
   logic [7:0]        pix_new;

   // shared adder and store ports
   mfde_pkg::alu_req_type alu_req;
   logic [REM_W-1:0]      alu_sum;
   logic                  st_wr_en, st_rd_en;
   logic [ADDR_W-1:0]     st_wr_addr, st_rd_addr;
   logic [7:0]            st_wr_data, st_rd_data;

   mfde_alu u_alu (
      .alu_req (alu_req),
      .alu_sum (alu_sum)
   );

   mfde_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // decode endpoints; a point is a line with equal endpoints
   always_comb begin
      x_a     = req_chan.x_start;
      y_a     = req_chan.y_start;
      x_b     = (req_chan.op == mfde_pkg::OP_POINT) ? req_chan.x_start : req_chan.x_end;
      y_b     = (req_chan.op == mfde_pkg::OP_POINT) ? req_chan.y_start : req_chan.y_end;
      swap    = x_b < x_a;
      x_lo    = swap ? x_b : x_a;
      x_hi    = swap ? x_a : x_b;
      y_at_lo = swap ? y_b : y_a;
      y_at_hi = swap ? y_a : y_b;
      y_min   = (y_b < y_a) ? y_b : y_a;
      y_max   = (y_b < y_a) ? y_a : y_b;
      vert_cmd = (x_a == x_b) && (y_a != y_b);
      read_in_range = ({2'b00, req_chan.read_column} < 9'(SCREEN_WIDTH)) &&
                      ({3'b000, req_chan.read_page} < 6'(PAGE_COUNT));
      read_addr = ADDR_W'(32'(req_chan.read_column) * PAGE_COUNT +
                          32'(req_chan.read_page));
   end

   // locate the current pixel and its store byte
   always_comb begin
      pix_col  = vert_ff ? fix_ff : cur_ff;
      pix_row  = vert_ff ? REM_W'(cur_ff) : (quo_ff + REM_W'(fix_ff));
      pix_on   = !pix_row[REM_W-1] && (pix_row < REM_W'(ROWS)) &&
                 ({1'b0, pix_col} < 9'(SCREEN_WIDTH));
      pix_addr = ADDR_W'(32'(pix_col) * PAGE_COUNT + 32'(pix_row[7:3]));
      pix_mask = 8'(1) << bit_ff;
      unique case (pen_ff)
         mfde_pkg::PEN_SET:    pix_new = st_rd_data | pix_mask;
         mfde_pkg::PEN_INVERT: pix_new = st_rd_data ^ pix_mask;
         default:              pix_new = st_rd_data & ~pix_mask;
      endcase
   end

   // select shared adder operands: compare against span, or step by dy
   always_comb begin
      alu_req.a = rem_ff;
      if (state_ff == mfde_pkg::S_NORM) begin
         alu_req.b   = REM_W'(span_ff);
         alu_req.sub = !rem_ff[REM_W-1];
      end else begin
         alu_req.b   = dy_ff;
         alu_req.sub = 1'b0;
      end
   end

   // store ports
   always_comb begin
      st_wr_en   = (state_ff == mfde_pkg::S_CLEAR) || (state_ff == mfde_pkg::S_FILL) ||
                   (state_ff == mfde_pkg::S_PLOT_WR);
      st_wr_addr = addr_ff;
      if (state_ff == mfde_pkg::S_PLOT_WR) begin
         st_wr_data = pix_new;
      end else if ((state_ff == mfde_pkg::S_FILL) && (pen_ff == mfde_pkg::PEN_SET)) begin
         st_wr_data = mfde_pkg::BYTE_ONES;
      end else begin
         st_wr_data = mfde_pkg::BYTE_ZEROS;
      end
      st_rd_en   = ((state_ff == mfde_pkg::S_PLOT_RD) && pix_on) ||
                   (state_ff == mfde_pkg::S_READ);
      st_rd_addr = (state_ff == mfde_pkg::S_PLOT_RD) ? pix_addr : addr_ff;
   end

   assign req_chan.ready     = (state_ff == mfde_pkg::S_IDLE) && !reset;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pen_in       = pen_ff;
      vert_in      = vert_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      fix_in       = fix_ff;
      dy_in        = dy_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      addr_in      = addr_ff;
      bit_in       = bit_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the response word once taken
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // zero the store after reset
         mfde_pkg::S_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = mfde_pkg::S_IDLE;
            end
         end

         // take a command word
         mfde_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               pen_in  = req_chan.pen;
               data_in = mfde_pkg::BYTE_ZEROS;
               unique case (req_chan.op)
                  mfde_pkg::OP_POINT, mfde_pkg::OP_LINE: begin
                     vert_in = vert_cmd;
                     rem_in  = '0;
                     quo_in  = '0;
                     if (vert_cmd) begin
                        cur_in  = y_min;
                        last_in = y_max;
                        fix_in  = x_a;
                        dy_in   = '0;
                        span_in = '0;
                     end else begin
                        cur_in  = x_lo;
                        last_in = x_hi;
                        fix_in  = y_at_lo;
                        dy_in   = REM_W'(y_at_hi) - REM_W'(y_at_lo);
                        span_in = x_hi - x_lo;
                     end
                     state_in = mfde_pkg::S_NORM;
                  end
                  mfde_pkg::OP_FILL: begin
                     addr_in = '0;
                     if ((req_chan.pen == mfde_pkg::PEN_SET) ||
                         (req_chan.pen == mfde_pkg::PEN_ERASE)) begin
                        state_in = mfde_pkg::S_FILL;
                     end else begin
                        state_in = mfde_pkg::S_DONE;
                     end
                  end
                  mfde_pkg::OP_READ: begin
                     addr_in  = read_addr;
                     state_in = read_in_range ? mfde_pkg::S_READ : mfde_pkg::S_DONE;
                  end
               endcase
            end
         end

         // bring the remainder into [0, span), or to zero for a zero span, moving the quotient
         mfde_pkg::S_NORM: begin
            priority if (rem_ff[REM_W-1]) begin
               rem_in = alu_sum;
               quo_in = quo_ff - 1'b1;
            end else if (!alu_sum[REM_W-1] && (span_ff != 8'd0)) begin
               rem_in = alu_sum;
               quo_in = quo_ff + 1'b1;
            end else begin
               state_in = mfde_pkg::S_PLOT_RD;
            end
         end

         // fetch the byte under the pixel, skip it when off screen
         mfde_pkg::S_PLOT_RD: begin
            addr_in  = pix_addr;
            bit_in   = pix_row[2:0];
            state_in = pix_on ? mfde_pkg::S_PLOT_WR : mfde_pkg::S_ADVANCE;
         end

         // write back the modified byte
         mfde_pkg::S_PLOT_WR: begin
            state_in = mfde_pkg::S_ADVANCE;
         end

         // advance the cursor and step the remainder by dy
         mfde_pkg::S_ADVANCE: begin
            if (cur_ff == last_ff) begin
               state_in = mfde_pkg::S_DONE;
            end else begin
               cur_in   = cur_ff + 1'b1;
               rem_in   = alu_sum;
               state_in = mfde_pkg::S_NORM;
            end
         end

         // sweep the store with the fill byte
         mfde_pkg::S_FILL: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = mfde_pkg::S_DONE;
            end
         end

         mfde_pkg::S_READ: begin
            state_in = mfde_pkg::S_READ_WAIT;
         end

         mfde_pkg::S_READ_WAIT: begin
            data_in  = st_rd_data;
            state_in = mfde_pkg::S_DONE;
         end

         // hand the word to the output register when it is free
         mfde_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff;
               state_in     = mfde_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mfde_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfde_pkg::S_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pen_ff      <= pen_in;
      vert_ff     <= vert_in;
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      fix_ff      <= fix_in;
      dy_ff       <= dy_in;
      span_ff     <= span_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      bit_ff      <= bit_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // a response word only appears after the final step of a command
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mfde_pkg::S_DONE))
      else $error("response raised outside the final step");

   // the remainder is normalized whenever a pixel is plotted
   a_rem_normalized: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mfde_pkg::S_PLOT_RD) |->
         (!rem_ff[REM_W-1] &&
          (((span_ff == 8'd0) && (rem_ff == '0)) || (rem_ff < REM_W'(span_ff)))))
      else $error("remainder out of range at plot");

   // one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("command taken while busy");
`endif

endmodule
`default_nettype wire

@@ bench/tb_mono_framebuffer_draw_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Framebuffer draw engine testbench
// Drives point, line, fill and read command words into the engine, predicts
// each response word from a private copy of the 128x64 pixel store, and
// compares every response in order. Directed corner commands run first, then
// about 2000 shaped random commands with sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_engine;

   localparam int SCREEN_W    = mfde_pkg::DEF_SCREEN_WIDTH;
   localparam int PAGES       = mfde_pkg::DEF_PAGE_COUNT;
   localparam int SCREEN_H    = PAGES * 8;
   localparam int STORE_SIZE  = SCREEN_W * PAGES;
   localparam int RANDOM_CMDS = 2000;
   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 50;
   localparam int REPORT_MAX  = 10;

   // pen code with no name of its own: behaves as clear on points and lines
   localparam logic [1:0] PEN_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic [1:0] pen;
      logic [6:0] read_column;
      logic [2:0] read_page;
   } draw_cmd_type;

   typedef struct {
      logic [1:0] op;
      logic [7:0] read_data;
   } rsp_word_type;

   logic clock;
   logic reset;

   mfde_req_if req_chan ();
   mfde_rsp_if rsp_chan ();

   mono_framebuffer_draw_engine #(
      .SCREEN_WIDTH (SCREEN_W),
      .PAGE_COUNT   (PAGES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predicted pixel store, one vertical byte per column and page
   logic [7:0] frame_bytes [STORE_SIZE];

   draw_cmd_type pending_cmds [$];
   rsp_word_type expected_rsps [$];
   draw_cmd_type in_flight;
   bit        send_busy;
   int        burst_left;
   int        gap_left;
   int        stall_left;
   int        idle_cycles;
   int        mismatch_count = 0;
   logic [15:0] cycle_count;
   int        last_x;
   int        last_y;

   // ------------------------------------------------------------------------
   // pixel store prediction
   // ------------------------------------------------------------------------
   function automatic void plot_pixel(int x, int y, logic [1:0] pen);
      int         idx;
      logic [7:0] mask;
      if (x >= SCREEN_W || y >= SCREEN_H || y < 0)
         return;
      idx  = x * PAGES + y / 8;
      mask = 8'h01 << (y % 8);
      case (pen)
         mfde_pkg::PEN_SET:    frame_bytes[idx] = frame_bytes[idx] | mask;
         mfde_pkg::PEN_INVERT: frame_bytes[idx] = frame_bytes[idx] ^ mask;
         default:              frame_bytes[idx] = frame_bytes[idx] & ~mask;
      endcase
   endfunction

   function automatic int floor_quot(int num, int den);
      int q;
      q = num / den;
      if ((num % den) != 0 && ((num < 0) != (den < 0)))
         q = q - 1;
      return q;
   endfunction

   function automatic void trace_line(int x1, int y1, int x2, int y2, logic [1:0] pen);
      int lo;
      int hi;
      int c;
      if (y1 == y2) begin
         lo = (x1 < x2) ? x1 : x2;
         hi = (x1 < x2) ? x2 : x1;
         for (c = lo; c <= hi; c++)
            plot_pixel(c, y1, pen);
      end else if (x1 == x2) begin
         lo = (y1 < y2) ? y1 : y2;
         hi = (y1 < y2) ? y2 : y1;
         for (c = lo; c <= hi; c++)
            plot_pixel(x1, c, pen);
      end else begin
         lo = (x1 < x2) ? x1 : x2;
         hi = (x1 < x2) ? x2 : x1;
         // exact rational row for each walked column, rows above the top skip
         for (c = lo; c <= hi; c++)
            plot_pixel(c, y1 + floor_quot((y2 - y1) * (c - x1), x2 - x1), pen);
      end
   endfunction

   // apply one command to the predicted store and return its response byte
   function automatic logic [7:0] apply_command(draw_cmd_type cmd);
      logic [7:0] data;
      data = mfde_pkg::BYTE_ZEROS;
      case (cmd.op)
         mfde_pkg::OP_POINT:
            plot_pixel(int'(cmd.x_start), int'(cmd.y_start), cmd.pen);
         mfde_pkg::OP_LINE:
            trace_line(int'(cmd.x_start), int'(cmd.y_start), int'(cmd.x_end),
                       int'(cmd.y_end), cmd.pen);
         mfde_pkg::OP_FILL: begin
            if (cmd.pen == mfde_pkg::PEN_SET || cmd.pen == mfde_pkg::PEN_ERASE)
               foreach (frame_bytes[i])
                  frame_bytes[i] = (cmd.pen == mfde_pkg::PEN_SET) ?
                                   mfde_pkg::BYTE_ONES : mfde_pkg::BYTE_ZEROS;
         end
         default: begin
            if (cmd.read_column < SCREEN_W && cmd.read_page < PAGES)
               data = frame_bytes[cmd.read_column * PAGES + cmd.read_page];
         end
      endcase
      return data;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void add_cmd(logic [1:0] op, int xs, int ys, int xe, int ye,
                                   logic [1:0] pen, int rc, int rp);
      draw_cmd_type cmd;
      cmd.op          = op;
      cmd.x_start     = xs[7:0];
      cmd.y_start     = ys[7:0];
      cmd.x_end       = xe[7:0];
      cmd.y_end       = ye[7:0];
      cmd.pen         = pen;
      cmd.read_column = rc[6:0];
      cmd.read_page   = rp[2:0];
      pending_cmds.push_back(cmd);
   endfunction

   function automatic int clamp_coord(int v);
      if (v < 0)
         return 0;
      if (v > 255)
         return 255;
      return v;
   endfunction

   function automatic logic [1:0] random_pen();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return mfde_pkg::PEN_SET;
      if (r < 6)
         return mfde_pkg::PEN_ERASE;
      if (r < 9)
         return mfde_pkg::PEN_INVERT;
      return PEN_SPARE;
   endfunction

   // mostly on-screen coordinate, now and then anywhere in the field range
   function automatic int random_coord(int span);
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 255);
      return $urandom_range(0, span - 1);
   endfunction

   function automatic void add_random_cmd();
      draw_cmd_type cmd;
      int        r;
      int        shape;
      cmd.op          = mfde_pkg::OP_READ;
      cmd.x_start     = 8'($urandom_range(0, 255));
      cmd.y_start     = 8'($urandom_range(0, 255));
      cmd.x_end       = 8'($urandom_range(0, 255));
      cmd.y_end       = 8'($urandom_range(0, 255));
      cmd.pen         = 2'($urandom_range(0, 3));
      cmd.read_column = 7'($urandom_range(0, 127));
      cmd.read_page   = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 38) begin
         cmd.op      = mfde_pkg::OP_POINT;
         cmd.x_start = 8'(random_coord(SCREEN_W));
         cmd.y_start = 8'(random_coord(SCREEN_H));
         cmd.pen     = random_pen();
      end else if (r < 62) begin
         cmd.op      = mfde_pkg::OP_LINE;
         cmd.x_start = 8'(random_coord(SCREEN_W));
         cmd.y_start = 8'(random_coord(SCREEN_H));
         cmd.pen     = random_pen();
         shape = $urandom_range(0, 3);
         // short spans keep the walk cheap; a few run the full field range
         if ($urandom_range(0, 19) == 0) begin
            cmd.x_end = 8'($urandom_range(0, 255));
            cmd.y_end = 8'($urandom_range(0, 255));
         end else begin
            cmd.x_end = 8'(clamp_coord(int'(cmd.x_start) + $urandom_range(0, 24) - 12));
            cmd.y_end = 8'(clamp_coord(int'(cmd.y_start) + $urandom_range(0, 80) - 40));
         end
         if (shape == 0)
            cmd.y_end = cmd.y_start;
         else if (shape == 1)
            cmd.x_end = cmd.x_start;
      end else if (r < 66) begin
         cmd.op = mfde_pkg::OP_FILL;
      end else if ($urandom_range(0, 1) == 0) begin
         // read back near the last drawn spot
         cmd.read_column = last_x[6:0];
         cmd.read_page   = last_y[5:3];
      end
      if (cmd.op == mfde_pkg::OP_POINT || cmd.op == mfde_pkg::OP_LINE) begin
         last_x = (cmd.x_start < SCREEN_W) ? int'(cmd.x_start) : int'(cmd.x_end) % SCREEN_W;
         last_y = int'(cmd.y_start) % SCREEN_H;
      end
      pending_cmds.push_back(cmd);
   endfunction

   function automatic void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("MISMATCH %s: expected read_data 0x%02h, got 0x%02h", what, want, got);
   endfunction

   // ------------------------------------------------------------------------
   // clock and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // command driver: bursts of words with random gaps
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.op          <= mfde_pkg::OP_POINT;
         req_chan.x_start     <= '0;
         req_chan.y_start     <= '0;
         req_chan.x_end       <= '0;
         req_chan.y_end       <= '0;
         req_chan.pen         <= mfde_pkg::PEN_ERASE;
         req_chan.read_column <= '0;
         req_chan.read_page   <= '0;
         foreach (frame_bytes[i])
            frame_bytes[i] = mfde_pkg::BYTE_ZEROS;
         send_busy  = 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_rsps.push_back('{in_flight.op, apply_command(in_flight)});
            send_busy = 1'b0;
         end
         if (!send_busy) begin
            if (gap_left != 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 8);
               in_flight = pending_cmds.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.op          <= in_flight.op;
               req_chan.x_start     <= in_flight.x_start;
               req_chan.y_start     <= in_flight.y_start;
               req_chan.x_end       <= in_flight.x_end;
               req_chan.y_end       <= in_flight.y_end;
               req_chan.pen         <= in_flight.pen;
               req_chan.read_column <= in_flight.read_column;
               req_chan.read_page   <= in_flight.read_page;
               send_busy = 1'b1;
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response stalls: phases of no stall, short, medium and long stalls
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left  <= 0;
         cycle_count <= '0;
      end else begin
         cycle_count <= cycle_count + 1'b1;
         if (stall_left != 0) begin
            stall_left     <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            case (cycle_count[12:11])
               2'd0: ;
               2'd1: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
               2'd2: if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(4, 16);
               default: if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(10, 40);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // response checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            note_mismatch("response word with no command outstanding",
                          mfde_pkg::BYTE_ZEROS, rsp_chan.read_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_chan.read_data !== want.read_data)
               note_mismatch($sformatf("op %0d", want.op), want.read_data,
                             rsp_chan.read_data);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: abort when no word moves on either channel for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      last_x = 0;
      last_y = 0;

      // store is cleared by reset
      add_cmd(mfde_pkg::OP_READ,    0,   0,   0,   0, mfde_pkg::PEN_ERASE,    0, 0);
      // corner pixels, pixels off either edge of the screen
      add_cmd(mfde_pkg::OP_POINT,   0,   0,   0,   0, mfde_pkg::PEN_SET,      0, 0);
      add_cmd(mfde_pkg::OP_POINT, 127,  63,   0,   0, mfde_pkg::PEN_SET,      0, 0);
      add_cmd(mfde_pkg::OP_POINT, 128,   5,   0,   0, mfde_pkg::PEN_SET,      0, 0);
      add_cmd(mfde_pkg::OP_POINT,   5,  64,   0,   0, mfde_pkg::PEN_SET,      0, 0);
      add_cmd(mfde_pkg::OP_POINT, 255, 255, 255, 255, mfde_pkg::PEN_INVERT, 127, 7);
      add_cmd(mfde_pkg::OP_READ,    0,   0,   0,   0, mfde_pkg::PEN_ERASE,    0, 0);
      add_cmd(mfde_pkg::OP_READ,  255, 255, 255, 255, PEN_SPARE,          127, 7);
      // horizontal and vertical spans running off the screen
      add_cmd(mfde_pkg::OP_LINE,  200,  10,   0,  10, mfde_pkg::PEN_SET,      0, 0);
      add_cmd(mfde_pkg::OP_LINE,    3, 255,   3,   0, mfde_pkg::PEN_INVERT,   0, 0);
      // sloped lines both ways, rows below the bottom skipped
      add_cmd(mfde_pkg::OP_LINE,    0,   0, 255, 255, mfde_pkg::PEN_SET,      0, 0);
      add_cmd(mfde_pkg::OP_LINE,    0, 255, 255,   0, mfde_pkg::PEN_INVERT,   0, 0);
      // equal endpoints draw one point
      add_cmd(mfde_pkg::OP_LINE,   10,   5,  10,   5, mfde_pkg::PEN_SET,      0, 0);
      // spare pen clears on lines and points
      add_cmd(mfde_pkg::OP_LINE,   20,  60,   5,   2, PEN_SPARE,            0, 0);
      add_cmd(mfde_pkg::OP_POINT,   3,  10,   0,   0, PEN_SPARE,            0, 0);
      add_cmd(mfde_pkg::OP_READ,    0,   0,   0,   0, mfde_pkg::PEN_ERASE,    3, 1);
      // fills that leave the store alone, then set and clear
      add_cmd(mfde_pkg::OP_FILL,    0,   0,   0,   0, mfde_pkg::PEN_INVERT,   0, 0);
      add_cmd(mfde_pkg::OP_FILL,    0,   0,   0,   0, PEN_SPARE,            0, 0);
      add_cmd(mfde_pkg::OP_READ,    0,   0,   0,   0, mfde_pkg::PEN_ERASE,    0, 1);
      add_cmd(mfde_pkg::OP_FILL,    0,   0,   0,   0, mfde_pkg::PEN_SET,      0, 0);
      add_cmd(mfde_pkg::OP_POINT,  64,  33,   0,   0, mfde_pkg::PEN_ERASE,    0, 0);
      add_cmd(mfde_pkg::OP_READ,    0,   0,   0,   0, mfde_pkg::PEN_ERASE,   64, 4);
      add_cmd(mfde_pkg::OP_FILL,    0,   0,   0,   0, mfde_pkg::PEN_ERASE,    0, 0);
      add_cmd(mfde_pkg::OP_READ,    0,   0,   0,   0, mfde_pkg::PEN_ERASE,   64, 4);

      repeat (RANDOM_CMDS)
         add_random_cmd();

      @(negedge reset);
      while (pending_cmds.size() != 0 || send_busy || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/mfde_pkg.sv
rtl/core/mfde_req_if.sv
rtl/core/mfde_rsp_if.sv
rtl/core/mfde_alu.sv
rtl/core/mfde_store.sv
rtl/core/mono_framebuffer_draw_engine.sv
bench/tb_mono_framebuffer_draw_engine.sv
